// ===== sv/wsd_pkg.sv =====
// Shared types and constants of the WAV stream decoder.
// Used by wsd_sample_unpack, wsd_parser and wav_stream_decoder; depends on nothing.
package wsd_pkg;

	// result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_ERROR  = 2'd1;
	localparam logic [1:0] KIND_SAMPLE = 2'd2;

	// header error codes
	localparam logic [2:0] ERR_RIFF       = 3'd0;
	localparam logic [2:0] ERR_WAVE       = 3'd1;
	localparam logic [2:0] ERR_FMT_TAG    = 3'd2;
	localparam logic [2:0] ERR_COMPRESSED = 3'd3;
	localparam logic [2:0] ERR_FMT_SIZE   = 3'd4;
	localparam logic [2:0] ERR_DATA_TAG   = 3'd5;
	localparam logic [2:0] ERR_SAMPLE_FMT = 3'd6;

	// chunk tags, little endian as assembled from the byte stream
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_FACT = 32'h7463_6166;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [11:0] DEADBAND_RESET = 12'd1200;

	// frame layouts, coded as bytes per frame
	localparam logic [2:0] FRAME_MONO8    = 3'd1;
	localparam logic [2:0] FRAME_MONO16   = 3'd2;
	localparam logic [2:0] FRAME_STEREO16 = 3'd4;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       file_start;
	} wsd_in_t;

	typedef struct packed {
		logic [1:0]         result_kind;
		logic [2:0]         error_code;
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
		logic [15:0]        channel_count;
		logic [15:0]        sample_bits;
		logic [31:0]        sample_rate;
		logic [31:0]        data_length;
		logic               end_of_data;
	} wsd_out_t;

	typedef struct packed {
		logic     has_result;
		wsd_out_t item;
	} wsd_res_t;

endpackage

// ===== sv/wsd_sample_unpack.sv =====
// Builds the left/right sample pair from a completed data frame.
// Depends on wsd_pkg for the frame layout codes.
module wsd_sample_unpack (
	input  logic [2:0]         frame_size,
	input  logic [7:0]         last_byte,
	input  logic [23:0]        partial,
	input  logic [11:0]        deadband,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample
);

	// push a sample away from zero by the deadband, saturating to 16 bits
	function automatic logic signed [15:0] push_away(input logic signed [15:0] s,
		input logic [11:0] d);
		logic signed [17:0] ext;
		logic signed [17:0] dd;
		logic signed [17:0] w;
		ext = {{2{s[15]}}, s};
		dd  = {6'b0, d};
		if (s > 16'sd0) begin
			w = ext + dd;
		end else begin
			w = ext - dd;
		end
		if (w > 18'sd32767) begin
			push_away = 16'sh7FFF;
		end else if (w < -18'sd32768) begin
			push_away = 16'sh8000;
		end else begin
			push_away = w[15:0];
		end
	endfunction

	always_comb begin
		case (frame_size)
			wsd_pkg::FRAME_MONO8: begin
				// recenter and scale by 256
				left_sample  = {~last_byte[7], last_byte[6:0], 8'h00};
				right_sample = {~last_byte[7], last_byte[6:0], 8'h00};
			end
			wsd_pkg::FRAME_MONO16: begin
				left_sample  = {last_byte, partial[7:0]};
				right_sample = {last_byte, partial[7:0]};
			end
			default: begin
				left_sample  = push_away(partial[15:0], deadband);
				right_sample = push_away({last_byte, partial[23:16]}, deadband);
			end
		endcase
	end

endmodule

// ===== sv/wsd_parser.sv =====
// Header parser and data-chunk tracker: per-byte state update and result.
// Depends on wsd_pkg and wsd_sample_unpack.
module wsd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  wsd_pkg::wsd_in_t  in_item,
	input  logic [11:0]       deadband,
	output wsd_pkg::wsd_res_t res
);

	localparam logic [4:0] PH_RIFF     = 5'd0;
	localparam logic [4:0] PH_CKSIZE   = 5'd1;
	localparam logic [4:0] PH_WAVE     = 5'd2;
	localparam logic [4:0] PH_FMT      = 5'd3;
	localparam logic [4:0] PH_FMTSIZE  = 5'd4;
	localparam logic [4:0] PH_FORMAT   = 5'd5;
	localparam logic [4:0] PH_CHANS    = 5'd6;
	localparam logic [4:0] PH_RATE     = 5'd7;
	localparam logic [4:0] PH_BRATE    = 5'd8;
	localparam logic [4:0] PH_ALIGN    = 5'd9;
	localparam logic [4:0] PH_BITS     = 5'd10;
	localparam logic [4:0] PH_CBSIZE   = 5'd11;
	localparam logic [4:0] PH_EXTSKIP  = 5'd12;
	localparam logic [4:0] PH_TAG      = 5'd13;
	localparam logic [4:0] PH_FACTBODY = 5'd14;
	localparam logic [4:0] PH_TAG2     = 5'd15;
	localparam logic [4:0] PH_DATALEN  = 5'd16;
	localparam logic [4:0] PH_STREAM   = 5'd17;
	localparam logic [4:0] PH_IDLE     = 5'd18;

	// fmt chunk size classes
	localparam logic [1:0] FMT_BAD   = 2'd0;
	localparam logic [1:0] FMT_PLAIN = 2'd1;
	localparam logic [1:0] FMT_EXT   = 2'd2;

	logic [4:0]  phase_q, phase_e, phase_n;
	logic [4:0]  count_q, count_e, count_n;
	logic [31:0] shift_q, shift_e, shift_n;
	logic [1:0]  fmt_q, fmt_e, fmt_n;
	logic [15:0] chans_q, chans_e, chans_n;
	logic [15:0] bits_q, bits_e, bits_n;
	logic [31:0] rate_q, rate_e, rate_n;
	logic [31:0] left_q, left_e, left_n;
	logic [1:0]  idx_q, idx_e, idx_n;
	logic [23:0] part_q, part_e, part_n;

	logic [31:0] taken;
	logic [4:0]  cnt_inc;
	logic [4:0]  need;
	logic        done;
	logic [31:0] left_dec;
	logic [2:0]  frame_size;
	logic [2:0]  idx_inc;
	logic        fmt_ok;
	logic signed [15:0] left_w, right_w;

	wsd_sample_unpack u_unpack (
		.frame_size  (frame_size),
		.last_byte   (in_item.file_byte),
		.partial     (part_e),
		.deadband    (deadband),
		.left_sample (left_w),
		.right_sample(right_w)
	);

	always_comb begin
		// a start byte sees cleared state
		phase_e = in_item.file_start ? PH_RIFF : phase_q;
		count_e = in_item.file_start ? 5'd0 : count_q;
		shift_e = in_item.file_start ? 32'd0 : shift_q;
		fmt_e   = in_item.file_start ? FMT_BAD : fmt_q;
		chans_e = in_item.file_start ? 16'd0 : chans_q;
		bits_e  = in_item.file_start ? 16'd0 : bits_q;
		rate_e  = in_item.file_start ? 32'd0 : rate_q;
		left_e  = in_item.file_start ? 32'd0 : left_q;
		idx_e   = in_item.file_start ? 2'd0 : idx_q;
		part_e  = in_item.file_start ? 24'd0 : part_q;

		taken = shift_e;
		if (count_e < 5'd4) begin
			taken = shift_e | ({24'b0, in_item.file_byte} << {count_e[1:0], 3'b000});
		end
		cnt_inc = count_e + 5'd1;

		case (phase_e)
			PH_FORMAT, PH_CHANS, PH_ALIGN, PH_BITS, PH_CBSIZE: need = 5'd2;
			PH_EXTSKIP:  need = 5'd22;
			PH_FACTBODY: need = 5'd8;
			default:     need = 5'd4;
		endcase
		done = cnt_inc >= need;

		left_dec   = left_e - 32'd1;
		frame_size = (bits_e == 16'd8) ? wsd_pkg::FRAME_MONO8 :
			((chans_e == 16'd2) ? wsd_pkg::FRAME_STEREO16 : wsd_pkg::FRAME_MONO16);
		idx_inc = {1'b0, idx_e} + 3'd1;
		fmt_ok  = (bits_e == 16'd8) ||
			((bits_e == 16'd16) && ((chans_e == 16'd1) || (chans_e == 16'd2)));

		phase_n = phase_e;
		count_n = count_e;
		shift_n = shift_e;
		fmt_n   = fmt_e;
		chans_n = chans_e;
		bits_n  = bits_e;
		rate_n  = rate_e;
		left_n  = left_e;
		idx_n   = idx_e;
		part_n  = part_e;
		res     = '0;

		if (phase_e < PH_STREAM) begin
			count_n = done ? 5'd0 : cnt_inc;
			shift_n = done ? 32'd0 : taken;
		end

		case (phase_e)
			PH_RIFF: begin
				if (done) begin
					phase_n = (taken == wsd_pkg::TAG_RIFF) ? PH_CKSIZE : PH_IDLE;
					res.has_result       = (taken != wsd_pkg::TAG_RIFF);
					res.item.result_kind = wsd_pkg::KIND_ERROR;
					res.item.error_code  = wsd_pkg::ERR_RIFF;
				end
			end
			PH_CKSIZE: begin
				if (done) begin
					phase_n = PH_WAVE;
				end
			end
			PH_WAVE: begin
				if (done) begin
					phase_n = (taken == wsd_pkg::TAG_WAVE) ? PH_FMT : PH_IDLE;
					res.has_result       = (taken != wsd_pkg::TAG_WAVE);
					res.item.result_kind = wsd_pkg::KIND_ERROR;
					res.item.error_code  = wsd_pkg::ERR_WAVE;
				end
			end
			PH_FMT: begin
				if (done) begin
					phase_n = (taken == wsd_pkg::TAG_FMT) ? PH_FMTSIZE : PH_IDLE;
					res.has_result       = (taken != wsd_pkg::TAG_FMT);
					res.item.result_kind = wsd_pkg::KIND_ERROR;
					res.item.error_code  = wsd_pkg::ERR_FMT_TAG;
				end
			end
			PH_FMTSIZE: begin
				if (done) begin
					phase_n = PH_FORMAT;
					if (taken == 32'd16) begin
						fmt_n = FMT_PLAIN;
					end else if ((taken == 32'd18) || (taken == 32'd40)) begin
						fmt_n = FMT_EXT;
					end else begin
						fmt_n = FMT_BAD;
					end
				end
			end
			PH_FORMAT: begin
				if (done) begin
					phase_n = (taken == 32'd1) ? PH_CHANS : PH_IDLE;
					res.has_result       = (taken != 32'd1);
					res.item.result_kind = wsd_pkg::KIND_ERROR;
					res.item.error_code  = wsd_pkg::ERR_COMPRESSED;
				end
			end
			PH_CHANS: begin
				if (done) begin
					chans_n = taken[15:0];
					phase_n = PH_RATE;
				end
			end
			PH_RATE: begin
				if (done) begin
					rate_n  = taken;
					phase_n = PH_BRATE;
				end
			end
			PH_BRATE: begin
				if (done) begin
					phase_n = PH_ALIGN;
				end
			end
			PH_ALIGN: begin
				if (done) begin
					phase_n = PH_BITS;
				end
			end
			PH_BITS: begin
				if (done) begin
					bits_n = taken[15:0];
					case (fmt_e)
						FMT_EXT:   phase_n = PH_CBSIZE;
						FMT_PLAIN: phase_n = PH_TAG;
						default: begin
							phase_n              = PH_IDLE;
							res.has_result       = 1'b1;
							res.item.result_kind = wsd_pkg::KIND_ERROR;
							res.item.error_code  = wsd_pkg::ERR_FMT_SIZE;
						end
					endcase
				end
			end
			PH_CBSIZE: begin
				if (done) begin
					phase_n = (taken[15:0] == 16'd22) ? PH_EXTSKIP : PH_TAG;
				end
			end
			PH_EXTSKIP: begin
				if (done) begin
					phase_n = PH_TAG;
				end
			end
			PH_TAG: begin
				if (done) begin
					if (taken == wsd_pkg::TAG_FACT) begin
						phase_n = PH_FACTBODY;
					end else if (taken == wsd_pkg::TAG_DATA) begin
						phase_n = PH_DATALEN;
					end else begin
						phase_n              = PH_IDLE;
						res.has_result       = 1'b1;
						res.item.result_kind = wsd_pkg::KIND_ERROR;
						res.item.error_code  = wsd_pkg::ERR_DATA_TAG;
					end
				end
			end
			PH_FACTBODY: begin
				if (done) begin
					phase_n = PH_TAG2;
				end
			end
			PH_TAG2: begin
				if (done) begin
					phase_n = (taken == wsd_pkg::TAG_DATA) ? PH_DATALEN : PH_IDLE;
					res.has_result       = (taken != wsd_pkg::TAG_DATA);
					res.item.result_kind = wsd_pkg::KIND_ERROR;
					res.item.error_code  = wsd_pkg::ERR_DATA_TAG;
				end
			end
			PH_DATALEN: begin
				if (done) begin
					res.has_result = 1'b1;
					if (!fmt_ok) begin
						phase_n              = PH_IDLE;
						res.item.result_kind = wsd_pkg::KIND_ERROR;
						res.item.error_code  = wsd_pkg::ERR_SAMPLE_FMT;
					end else begin
						left_n  = taken;
						idx_n   = 2'd0;
						part_n  = 24'd0;
						phase_n = (taken == 32'd0) ? PH_IDLE : PH_STREAM;
						res.item.result_kind   = wsd_pkg::KIND_HEADER;
						res.item.channel_count = chans_e;
						res.item.sample_bits   = bits_e;
						res.item.sample_rate   = rate_e;
						res.item.data_length   = taken;
					end
				end
			end
			PH_STREAM: begin
				left_n = left_dec;
				if (left_dec == 32'd0) begin
					phase_n = PH_IDLE;
				end
				if (idx_inc < frame_size) begin
					// collect an earlier byte of the frame
					case (idx_e)
						2'd0:    part_n[7:0]   = part_e[7:0] | in_item.file_byte;
						2'd1:    part_n[15:8]  = part_e[15:8] | in_item.file_byte;
						2'd2:    part_n[23:16] = part_e[23:16] | in_item.file_byte;
						default: part_n        = part_e;
					endcase
					idx_n = idx_inc[1:0];
				end else begin
					idx_n  = 2'd0;
					part_n = 24'd0;
					res.has_result        = 1'b1;
					res.item.result_kind  = wsd_pkg::KIND_SAMPLE;
					res.item.left_sample  = left_w;
					res.item.right_sample = right_w;
					res.item.end_of_data  = (left_dec < {29'b0, frame_size});
				end
			end
			default: ;
		endcase

		// the item is cleared when there is no result, so error fields stay zero unless this is an error result
		if (!res.has_result) begin
			res.item = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF;
			count_q <= 5'd0;
			shift_q <= 32'd0;
			fmt_q   <= FMT_BAD;
			chans_q <= 16'd0;
			bits_q  <= 16'd0;
			rate_q  <= 32'd0;
			left_q  <= 32'd0;
			idx_q   <= 2'd0;
			part_q  <= 24'd0;
		end else if (fire) begin
			phase_q <= phase_n;
			count_q <= count_n;
			shift_q <= shift_n;
			fmt_q   <= fmt_n;
			chans_q <= chans_n;
			bits_q  <= bits_n;
			rate_q  <= rate_n;
			left_q  <= left_n;
			idx_q   <= idx_n;
			part_q  <= part_n;
		end
	end

endmodule

// ===== sv/wav_stream_decoder.sv =====
// WAV stream decoder: input register, parser and result register.
// A byte is held in the input register and any result of it in the output register.
// Throughput: one byte per clock unless stalled; one parser state update per byte.
// With the output stalled, the input register still takes a byte if it is empty.
// Reset (arst_n low, asynchronous) clears parser state to expect the RIFF tag and
// sets deadband_q to 1200; depends on wsd_pkg and wsd_parser.
module wav_stream_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  wsd_pkg::wsd_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output wsd_pkg::wsd_out_t out_data,
	input  logic              cfg_wr_en,
	input  logic [11:0]       cfg_wr_data
);

	logic              valid_s1;
	wsd_pkg::wsd_in_t  item_s1;
	logic              out_valid_q;
	wsd_pkg::wsd_out_t out_q;
	logic [11:0]       deadband_q;
	logic              advance;
	logic              fire;
	logic              accept;
	wsd_pkg::wsd_res_t res;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	wsd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.in_item (item_s1),
		.deadband(deadband_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.has_result) begin
			out_q <= res.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= wsd_pkg::DEADBAND_RESET;
		end else if (cfg_wr_en) begin
			deadband_q <= cfg_wr_data;
		end
	end

	// hold a stalled byte in the input register
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_stall |=> valid_s1)
		else $error("input byte lost while stalled");

	// hold a stalled result in the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("result dropped while stalled");

	// no byte is parsed while the output register is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !fire)
		else $error("parser advanced into a full output register");

	// end of data marks sample pairs only
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.end_of_data |-> out_q.result_kind == wsd_pkg::KIND_SAMPLE)
		else $error("end of data on a non-sample result");

endmodule
